[src/kpsm_pkg.sv]
// ----------------------------------------------------------------------------
// kpsm_pkg
// Types, constants and symbol tables shared by the keypad scanner modules.
// ----------------------------------------------------------------------------
package kpsm_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2,
    PH_TAP      = 2'd3
  } phase_e;

  // configuration register indexes
  localparam logic [1:0] CFG_NUMERIC_MODE   = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [1:0] CFG_TAP_TIMEOUT    = 2'd2;

  localparam int unsigned CfgDataW = 11;

  localparam logic [7:0]  DEBOUNCE_RESET = 8'd10;
  localparam logic [10:0] TIMEOUT_RESET  = 11'd1200;
  localparam logic [7:0]  DEBOUNCE_MAX   = 8'd255;
  localparam logic [10:0] TIMER_MAX      = 11'd2047;
  localparam logic [2:0]  TAP_RESET      = 3'd1;
  localparam logic [7:0]  CHAR_HASH      = 8'h23;

  localparam logic [7:0] KEY_SYMS [12][5] = '{
    '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00},  // 1
    '{8'h32, 8'h41, 8'h42, 8'h43, 8'h00},  // 2ABC
    '{8'h33, 8'h44, 8'h45, 8'h46, 8'h00},  // 3DEF
    '{8'h34, 8'h47, 8'h48, 8'h49, 8'h00},  // 4GHI
    '{8'h35, 8'h4A, 8'h4B, 8'h4C, 8'h00},  // 5JKL
    '{8'h36, 8'h4D, 8'h4E, 8'h4F, 8'h00},  // 6MNO
    '{8'h37, 8'h50, 8'h51, 8'h52, 8'h53},  // 7PQRS
    '{8'h38, 8'h54, 8'h55, 8'h56, 8'h00},  // 8TUV
    '{8'h39, 8'h57, 8'h58, 8'h59, 8'h5A},  // 9WXYZ
    '{8'h2A, 8'h00, 8'h00, 8'h00, 8'h00},  // *
    '{8'h30, 8'h20, 8'h00, 8'h00, 8'h00},  // 0 and space
    '{8'h23, 8'h00, 8'h00, 8'h00, 8'h00}   // #
  };

  localparam logic [2:0] KEY_COUNT [12] = '{
    3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd1, 3'd2, 3'd1
  };

  typedef struct packed {
    logic [2:0] column_drive;
    logic       key_valid;
    logic [7:0] key_char;
    logic       show_valid;
    logic [7:0] show_char;
    logic       erase_last;
  } kpsm_res_t;

  typedef struct packed {
    logic        numeric_mode;
    logic [7:0]  debounce_ticks;
    logic [10:0] tap_timeout;
  } kpsm_cfg_t;

  function automatic logic [1:0] lowest_row(input logic [3:0] rows);
    logic [1:0] r;
    if (rows[0]) r = 2'd0;
    else if (rows[1]) r = 2'd1;
    else if (rows[2]) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  function automatic logic [3:0] held_key(input logic [1:0] row, input logic [1:0] col);
    logic [1:0] c;
    c = (col > 2'd2) ? 2'd2 : col;
    return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, c};
  endfunction

  function automatic logic [7:0] sym_at(input logic [3:0] key, input logic [2:0] idx);
    logic [7:0] s;
    if (idx < KEY_COUNT[key]) s = KEY_SYMS[key][idx];
    else s = KEY_SYMS[key][0];
    return s;
  endfunction

  function automatic logic [1:0] next_column(input logic [1:0] col);
    return (col >= 2'd2) ? 2'd0 : col + 2'd1;
  endfunction

  function automatic logic [2:0] col_drive(input logic [1:0] col);
    logic [2:0] d;
    case (col)
      2'd0:    d = 3'b100;
      2'd1:    d = 3'b010;
      2'd2:    d = 3'b001;
      default: d = 3'b000;
    endcase
    return d;
  endfunction

endpackage

[src/kpsm_if.sv]
// ----------------------------------------------------------------------------
// kpsm_in_if / kpsm_out_if
// Valid/ready channels for poll requests and scan results.
// ----------------------------------------------------------------------------
interface kpsm_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_lines;
  logic       tick;

  modport source (output valid, output row_lines, output tick, input ready);
  modport sink (input valid, input row_lines, input tick, output ready);
endinterface

interface kpsm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] column_drive;
  logic       key_valid;
  logic [7:0] key_char;
  logic       show_valid;
  logic [7:0] show_char;
  logic       erase_last;

  modport source (
    output valid, output column_drive, output key_valid, output key_char,
    output show_valid, output show_char, output erase_last, input ready
  );
  modport sink (
    input valid, input column_drive, input key_valid, input key_char,
    input show_valid, input show_char, input erase_last, output ready
  );
endinterface

[src/kpsm_core.sv]
// ----------------------------------------------------------------------------
// kpsm_core
// Scan state, debounce and multitap logic; one poll per accepted request.
// ----------------------------------------------------------------------------
module kpsm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                poll_i,
  input  logic [3:0]          row_lines_i,
  input  logic                tick_i,
  input  kpsm_pkg::kpsm_cfg_t cfg_i,
  output kpsm_pkg::kpsm_res_t res_o
);

  kpsm_pkg::phase_e phase_q, phase_d;
  logic [1:0]  scan_q, scan_d;
  logic [1:0]  hrow_q, hrow_d;
  logic [1:0]  hcol_q, hcol_d;
  logic [2:0]  tap_q, tap_d;
  logic [7:0]  dc_q, dc_d, dc_t;
  logic [10:0] tt_q, tt_d, tt_t;

  logic        pressed;
  logic [1:0]  row_lo;
  logic [3:0]  key;
  logic [7:0]  sym_cur;
  logic [7:0]  sym_first;
  logic        deb_done;
  logic        timeout_hit;
  logic        same_key;
  logic [3:0]  tap_next;

  assign pressed     = |row_lines_i;
  assign row_lo      = kpsm_pkg::lowest_row(row_lines_i);
  assign key         = kpsm_pkg::held_key(hrow_q, hcol_q);
  assign sym_cur     = kpsm_pkg::sym_at(key, tap_q);
  assign sym_first   = kpsm_pkg::KEY_SYMS[key][0];
  assign dc_t        = (tick_i && dc_q < kpsm_pkg::DEBOUNCE_MAX) ? dc_q + 8'd1 : dc_q;
  assign tt_t        = (tick_i && tt_q < kpsm_pkg::TIMER_MAX) ? tt_q + 11'd1 : tt_q;
  assign deb_done    = dc_t >= cfg_i.debounce_ticks;
  assign timeout_hit = tt_t >= cfg_i.tap_timeout;
  assign same_key    = (row_lo == hrow_q) && (scan_q == hcol_q);
  assign tap_next    = {1'b0, tap_q} + 4'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      kpsm_pkg::PH_IDLE: begin
        if (pressed) phase_d = kpsm_pkg::PH_DEBOUNCE;
      end
      kpsm_pkg::PH_DEBOUNCE: begin
        if (deb_done) phase_d = pressed ? kpsm_pkg::PH_HOLD : kpsm_pkg::PH_IDLE;
      end
      kpsm_pkg::PH_HOLD: begin
        if (!pressed) phase_d = kpsm_pkg::PH_TAP;
      end
      kpsm_pkg::PH_TAP: begin
        if (cfg_i.numeric_mode || timeout_hit || pressed) phase_d = kpsm_pkg::PH_IDLE;
      end
      default: phase_d = kpsm_pkg::PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    scan_d = scan_q;
    hrow_d = hrow_q;
    hcol_d = hcol_q;
    tap_d  = tap_q;
    dc_d   = dc_t;
    tt_d   = tt_t;
    res_o  = '0;
    unique case (phase_q)
      kpsm_pkg::PH_IDLE: begin
        if (pressed) begin
          hrow_d = row_lo;
          hcol_d = scan_q;
          dc_d   = '0;
        end else begin
          scan_d = kpsm_pkg::next_column(scan_q);
        end
      end
      kpsm_pkg::PH_DEBOUNCE: begin
        if (deb_done && pressed) tt_d = '0;
      end
      kpsm_pkg::PH_HOLD: begin
        if (!pressed && !cfg_i.numeric_mode && sym_first != kpsm_pkg::CHAR_HASH) begin
          res_o.show_valid = 1'b1;
          res_o.show_char  = sym_cur;
        end
      end
      kpsm_pkg::PH_TAP: begin
        scan_d = kpsm_pkg::next_column(scan_q);
        if (cfg_i.numeric_mode) begin
          res_o.key_valid = 1'b1;
          res_o.key_char  = sym_first;
        end else if (timeout_hit || (pressed && !same_key)) begin
          res_o.key_valid = 1'b1;
          res_o.key_char  = sym_cur;
          tap_d           = kpsm_pkg::TAP_RESET;
        end else if (pressed) begin
          tap_d            = (tap_next >= {1'b0, kpsm_pkg::KEY_COUNT[key]}) ? 3'd0
                                                                           : tap_next[2:0];
          res_o.erase_last = 1'b1;
        end
      end
      default: ;
    endcase
    res_o.column_drive = kpsm_pkg::col_drive(scan_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpsm_pkg::PH_IDLE;
      scan_q  <= '0;
      hrow_q  <= '0;
      hcol_q  <= '0;
      tap_q   <= kpsm_pkg::TAP_RESET;
      dc_q    <= '0;
      tt_q    <= '0;
    end else if (poll_i) begin
      phase_q <= phase_d;
      scan_q  <= scan_d;
      hrow_q  <= hrow_d;
      hcol_q  <= hcol_d;
      tap_q   <= tap_d;
      dc_q    <= dc_d;
      tt_q    <= tt_d;
    end
  end

endmodule

[src/kpsm_skid.sv]
// ----------------------------------------------------------------------------
// kpsm_skid
// Output register with a skid stage so one further request can be accepted under a stall.
// ----------------------------------------------------------------------------
module kpsm_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kpsm_pkg::kpsm_res_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kpsm_pkg::kpsm_res_t out_data_o
);

  logic                out_valid_q, skid_valid_q;
  kpsm_pkg::kpsm_res_t out_q, skid_q;
  logic                take;
  logic                push;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !take) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !take) skid_q <= in_data_i;
      else out_q <= in_data_i;
    end
  end

endmodule

[src/keypad_scan_multitap.sv]
// ----------------------------------------------------------------------------
// keypad_scan_multitap
// 4x3 matrix keypad scanner with debounce and multitap letter entry.
//
// Each request on in_if is one poll: the row lines sensed under the previous
// column_drive and a flag that one timer tick has passed. Every poll gives
// exactly one result on out_if: the next column drive, a committed key
// (key_valid/key_char) and the provisional multitap character controls
// (show_valid/show_char/erase_last).
// The scan state is updated in the cycle a request is accepted, and the
// result is registered in the output register, or in the skid stage while
// the output register is held by a stall. A request can be accepted every
// cycle while the skid stage is empty; throughput is then one poll per cycle.
// When the receiver stalls, one further result is held in a skid stage;
// in_if.ready drops only while that stage is occupied.
// Reset clears the scan state and loads numeric mode, a debounce limit of
// 10 ticks and a tap timeout of 1200 ticks. Configuration writes on
// cfg_we_i / cfg_idx_i / cfg_data_i take effect once registered in cfg_q.
// ----------------------------------------------------------------------------
module keypad_scan_multitap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  kpsm_in_if.sink                         in_if,
  kpsm_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [kpsm_pkg::CfgDataW-1:0]   cfg_data_i
);

  kpsm_pkg::kpsm_cfg_t cfg_q;
  kpsm_pkg::kpsm_res_t res;
  kpsm_pkg::kpsm_res_t out_data;
  logic                in_ready;
  logic                poll;

  assign in_if.ready = in_ready;
  assign poll        = in_if.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.numeric_mode   <= 1'b1;
      cfg_q.debounce_ticks <= kpsm_pkg::DEBOUNCE_RESET;
      cfg_q.tap_timeout    <= kpsm_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kpsm_pkg::CFG_NUMERIC_MODE:   cfg_q.numeric_mode   <= cfg_data_i[0];
        kpsm_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data_i[7:0];
        kpsm_pkg::CFG_TAP_TIMEOUT:    cfg_q.tap_timeout    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  kpsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poll_i      (poll),
    .row_lines_i (in_if.row_lines),
    .tick_i      (in_if.tick),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  kpsm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (res),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data)
  );

  assign out_if.column_drive = out_data.column_drive;
  assign out_if.key_valid    = out_data.key_valid;
  assign out_if.key_char     = out_data.key_char;
  assign out_if.show_valid   = out_data.show_valid;
  assign out_if.show_char    = out_data.show_char;
  assign out_if.erase_last   = out_data.erase_last;

endmodule
